// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SIT_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");

`else

`define SIT_ASSERT_IMPL(lbl, ant, cons)
`define SIT_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int TOL_WIDTH       = 16;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_COORDS      = 8;
    localparam int OUT_TDATA_WIDTH = 8;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_DEGEN  = 2'd1,
        VERDICT_PROPER = 2'd2
    } verdict_t;

endpackage

// ===== rtl/sit_diff.sv =====
// ----------------------------------------------------------------------------
// sit_diff
// First stage: unpacks the coordinates and forms direction and offset vectors.
// ----------------------------------------------------------------------------
module sit_diff #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [sit_pkg::NUM_COORDS*COORD_WIDTH-1:0]  coords,
    output logic                                        valid,
    output logic signed [COORD_WIDTH:0]                 dax,
    output logic signed [COORD_WIDTH:0]                 day,
    output logic signed [COORD_WIDTH:0]                 dbx,
    output logic signed [COORD_WIDTH:0]                 dby,
    output logic signed [COORD_WIDTH:0]                 rx,
    output logic signed [COORD_WIDTH:0]                 ry
);

    localparam int W = COORD_WIDTH;

    logic signed [W:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic              valid_reg;
    logic signed [W:0] dax_reg, day_reg, dbx_reg, dby_reg, rx_reg, ry_reg;

    // sign-extend each coordinate by one bit so differences cannot wrap
    assign ax0 = $signed({coords[0*W+W-1], coords[0*W +: W]});
    assign ay0 = $signed({coords[1*W+W-1], coords[1*W +: W]});
    assign ax1 = $signed({coords[2*W+W-1], coords[2*W +: W]});
    assign ay1 = $signed({coords[3*W+W-1], coords[3*W +: W]});
    assign bx0 = $signed({coords[4*W+W-1], coords[4*W +: W]});
    assign by0 = $signed({coords[5*W+W-1], coords[5*W +: W]});
    assign bx1 = $signed({coords[6*W+W-1], coords[6*W +: W]});
    assign by1 = $signed({coords[7*W+W-1], coords[7*W +: W]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg <= ax1 - ax0;
            day_reg <= ay1 - ay0;
            dbx_reg <= bx1 - bx0;
            dby_reg <= by1 - by0;
            rx_reg  <= ax0 - bx0;
            ry_reg  <= ay0 - by0;
        end
    end

    assign valid = valid_reg;
    assign dax   = dax_reg;
    assign day   = day_reg;
    assign dbx   = dbx_reg;
    assign dby   = dby_reg;
    assign rx    = rx_reg;
    assign ry    = ry_reg;

endmodule

// ===== rtl/sit_cross.sv =====
// ----------------------------------------------------------------------------
// sit_cross
// Two stages: six exact products, then the three cross products d, ns, nt.
// ----------------------------------------------------------------------------
module sit_cross #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COORD_WIDTH:0]       dax,
    input  logic signed [COORD_WIDTH:0]       day,
    input  logic signed [COORD_WIDTH:0]       dbx,
    input  logic signed [COORD_WIDTH:0]       dby,
    input  logic signed [COORD_WIDTH:0]       rx,
    input  logic signed [COORD_WIDTH:0]       ry,
    output logic                              valid,
    output logic signed [2*COORD_WIDTH+2:0]   d,
    output logic signed [2*COORD_WIDTH+2:0]   ns,
    output logic signed [2*COORD_WIDTH+2:0]   nt
);

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int CW = PW + 1;

    logic              prod_vld_reg;
    logic signed [PW-1:0] p_dbx_day_reg, p_dby_dax_reg;
    logic signed [PW-1:0] p_rx_day_reg, p_ry_dax_reg;
    logic signed [PW-1:0] p_rx_dby_reg, p_ry_dbx_reg;
    logic              cross_vld_reg;
    logic signed [CW-1:0] d_reg, ns_reg, nt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            cross_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_vld_reg  <= in_valid;
            cross_vld_reg <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_dbx_day_reg <= PW'(dbx) * PW'(day);
            p_dby_dax_reg <= PW'(dby) * PW'(dax);
            p_rx_day_reg  <= PW'(rx) * PW'(day);
            p_ry_dax_reg  <= PW'(ry) * PW'(dax);
            p_rx_dby_reg  <= PW'(rx) * PW'(dby);
            p_ry_dbx_reg  <= PW'(ry) * PW'(dbx);
            d_reg  <= CW'(p_dbx_day_reg) - CW'(p_dby_dax_reg);
            ns_reg <= CW'(p_rx_day_reg) - CW'(p_ry_dax_reg);
            nt_reg <= CW'(p_rx_dby_reg) - CW'(p_ry_dbx_reg);
        end
    end

    assign valid = cross_vld_reg;
    assign d     = d_reg;
    assign ns    = ns_reg;
    assign nt    = nt_reg;

endmodule

// ===== rtl/sit_norm.sv =====
// ----------------------------------------------------------------------------
// sit_norm
// Two stages: force d positive (negating ns and nt with it), then scale |d|
// by the tolerance.
// ----------------------------------------------------------------------------
module sit_norm #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [2*COORD_WIDTH+2:0]         d,
    input  logic signed [2*COORD_WIDTH+2:0]         ns,
    input  logic signed [2*COORD_WIDTH+2:0]         nt,
    input  logic [sit_pkg::TOL_WIDTH-1:0]           tol,
    output logic                                    valid,
    output logic                                    dzero,
    output logic signed [2*COORD_WIDTH+2:0]         dabs,
    output logic signed [2*COORD_WIDTH+2:0]         ns_pos,
    output logic signed [2*COORD_WIDTH+2:0]         nt_pos,
    output logic [2*COORD_WIDTH+1+sit_pkg::TOL_WIDTH:0] dtol
);

    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int MW = CW - 1 + sit_pkg::TOL_WIDTH;

    logic                 neg;
    logic                 sign_vld_reg, scale_vld_reg;
    logic                 dzero_a_reg, dzero_b_reg;
    logic signed [CW-1:0] dabs_a_reg, ns_a_reg, nt_a_reg;
    logic signed [CW-1:0] dabs_b_reg, ns_b_reg, nt_b_reg;
    logic [MW-1:0]        dtol_reg;

    assign neg = d[CW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_vld_reg  <= 1'b0;
            scale_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sign_vld_reg  <= in_valid;
            scale_vld_reg <= sign_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dzero_a_reg <= (d == '0);
            dabs_a_reg  <= neg ? -d  : d;
            ns_a_reg    <= neg ? -ns : ns;
            nt_a_reg    <= neg ? -nt : nt;
            // |d| has a clear sign bit, so the product is unsigned
            dtol_reg    <= MW'(dabs_a_reg[CW-2:0]) * MW'(tol);
            dzero_b_reg <= dzero_a_reg;
            dabs_b_reg  <= dabs_a_reg;
            ns_b_reg    <= ns_a_reg;
            nt_b_reg    <= nt_a_reg;
        end
    end

    assign valid  = scale_vld_reg;
    assign dzero  = dzero_b_reg;
    assign dabs   = dabs_b_reg;
    assign ns_pos = ns_b_reg;
    assign nt_pos = nt_b_reg;
    assign dtol   = dtol_reg;

endmodule

// ===== rtl/sit_judge.sv =====
// ----------------------------------------------------------------------------
// sit_judge
// Last stage: band and parameter compares, verdict into the output register.
// ----------------------------------------------------------------------------
module sit_judge #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic                                        dzero,
    input  logic signed [2*COORD_WIDTH+2:0]             dabs,
    input  logic signed [2*COORD_WIDTH+2:0]             ns_pos,
    input  logic signed [2*COORD_WIDTH+2:0]             nt_pos,
    input  logic [2*COORD_WIDTH+1+sit_pkg::TOL_WIDTH:0] dtol,
    output logic                                        valid,
    output sit_pkg::verdict_t                           verdict
);

    localparam int CW  = 2 * COORD_WIDTH + 3;
    localparam int MW  = CW - 1 + sit_pkg::TOL_WIDTH;
    localparam int LW  = CW + sit_pkg::FRAC_BITS + 2;
    localparam int PAD = LW - MW;

    logic signed [LW-1:0] ns16, d16, p, lo_out, hi_out, hi_near;
    logic                 out_band, near_end, t_bad;
    sit_pkg::verdict_t    verdict_next;
    logic                 valid_reg;
    sit_pkg::verdict_t    verdict_reg;

    assign ns16    = $signed({{2{ns_pos[CW-1]}}, ns_pos, {sit_pkg::FRAC_BITS{1'b0}}});
    assign d16     = $signed({2'b00, dabs, {sit_pkg::FRAC_BITS{1'b0}}});
    assign p       = $signed({{PAD{1'b0}}, dtol});
    assign lo_out  = -p;
    assign hi_out  = d16 + p;
    assign hi_near = d16 - p;

    always_comb
    begin
        out_band = (ns16 < lo_out) || (ns16 > hi_out);
        near_end = (ns16 < p) || (ns16 > hi_near);
        t_bad    = nt_pos[CW-1] || (nt_pos > dabs);
        if (dzero)
        begin
            verdict_next = sit_pkg::VERDICT_DEGEN;
        end
        else if (out_band)
        begin
            verdict_next = sit_pkg::VERDICT_NONE;
        end
        else if (near_end)
        begin
            verdict_next = sit_pkg::VERDICT_DEGEN;
        end
        else if (t_bad)
        begin
            verdict_next = sit_pkg::VERDICT_NONE;
        end
        else
        begin
            verdict_next = sit_pkg::VERDICT_PROPER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign valid   = valid_reg;
    assign verdict = verdict_reg;

endmodule

// ===== rtl/segment_intersection_test_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Pipeline: six register stages (diff, two cross, two norm, judge); the verdict
// leaves from the last of them, the output register.
// Throughput: one segment pair per cycle; the six register stages advance
// together and hold as a whole while the output register waits on tready.
// Reset: rst_n clears all stage valid bits and the tolerance register to 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // tolerance write channel
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [sit_pkg::TOL_WIDTH-1:0]                cfg_data,
    // input segment pairs
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata: a_start_x, a_start_y, a_end_x, a_end_y,
    //        b_start_x, b_start_y, b_end_x, b_end_y (lowest first)
    input  logic [sit_pkg::NUM_COORDS*COORD_WIDTH-1:0]   s_axis_tdata,
    // verdicts
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // tdata: verdict in [1:0], zero above
    output logic [sit_pkg::OUT_TDATA_WIDTH-1:0]          m_axis_tdata
);

    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int MW = CW - 1 + sit_pkg::TOL_WIDTH;

    logic                          en;
    logic [sit_pkg::TOL_WIDTH-1:0] tol_reg;

    logic                      diff_vld;
    logic signed [COORD_WIDTH:0] dax, day, dbx, dby, rx, ry;
    logic                      cross_vld;
    logic signed [CW-1:0]      d, ns, nt;
    logic                      norm_vld, dzero;
    logic signed [CW-1:0]      dabs, ns_pos, nt_pos;
    logic [MW-1:0]             dtol;
    logic                      judge_vld;
    sit_pkg::verdict_t         verdict;

    // advance the whole pipe unless a finished verdict is blocked
    assign en            = !judge_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    sit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .coords   (s_axis_tdata),
        .valid    (diff_vld),
        .dax      (dax),
        .day      (day),
        .dbx      (dbx),
        .dby      (dby),
        .rx       (rx),
        .ry       (ry)
    );

    sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (diff_vld),
        .dax      (dax),
        .day      (day),
        .dbx      (dbx),
        .dby      (dby),
        .rx       (rx),
        .ry       (ry),
        .valid    (cross_vld),
        .d        (d),
        .ns       (ns),
        .nt       (nt)
    );

    sit_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cross_vld),
        .d        (d),
        .ns       (ns),
        .nt       (nt),
        .tol      (tol_reg),
        .valid    (norm_vld),
        .dzero    (dzero),
        .dabs     (dabs),
        .ns_pos   (ns_pos),
        .nt_pos   (nt_pos),
        .dtol     (dtol)
    );

    sit_judge #(.COORD_WIDTH(COORD_WIDTH)) u_judge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (norm_vld),
        .dzero    (dzero),
        .dabs     (dabs),
        .ns_pos   (ns_pos),
        .nt_pos   (nt_pos),
        .dtol     (dtol),
        .valid    (judge_vld),
        .verdict  (verdict)
    );

    assign m_axis_tvalid = judge_vld;
    assign m_axis_tdata  = {{(sit_pkg::OUT_TDATA_WIDTH - $bits(sit_pkg::verdict_t)){1'b0}},
                            verdict};

    // an accepted transaction shows up in the first stage
    `SIT_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, diff_vld)
    // a stall keeps the item parked in the scaling stage
    `SIT_ASSERT_NEXT(a_stall_holds, !en && norm_vld, norm_vld && judge_vld)
    // non-negative |d| after sign correction
    `SIT_ASSERT_IMPL(a_dabs_pos, norm_vld, !dabs[CW-1])

endmodule

// ===== dv/tb_segment_intersection_test_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_core
// Streams segment pairs into the intersection core and checks every verdict.
// A short table of hand-picked pairs covers parallel, collinear, coordinate
// extremes, exact endpoint touches and the tolerance band. Random pairs follow
// over several tolerance settings. Verdicts come from an exact integer
// predictor or are typed into the table. Both stream sides idle at random, and
// the output side holds off once for a long stretch to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_core;
    import sit_pkg::*;

    localparam int CW               = 16;
    localparam int LATENCY          = 6;
    localparam int DRAIN_CYCLES     = 4 * LATENCY;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PAIRS_PER_PHASE  = 66;
    localparam int HOLD_AT_VERDICT  = 80;
    localparam int HOLD_CYCLES      = 300;
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_ROWS         = 25;
    localparam int NUM_PHASES       = 8;
    localparam int TOL_RANDOM       = -1;
    localparam int TOL_PHASES [NUM_PHASES] =
        '{0, 65535, 32768, 1, TOL_RANDOM, 6554, 2048, TOL_RANDOM};

    typedef logic signed [CW-1:0] coord_t;

    // declared highest field first so that a_start_x lands in the lowest bits
    typedef struct packed {
        coord_t b_end_y;
        coord_t b_end_x;
        coord_t b_start_y;
        coord_t b_start_x;
        coord_t a_end_y;
        coord_t a_end_x;
        coord_t a_start_y;
        coord_t a_start_x;
    } seg_pair_t;

    typedef struct {
        int       tol;
        int       ax0, ay0, ax1, ay1;
        int       bx0, by0, bx1, by1;
        bit       typed;
        verdict_t want;
    } stim_row_t;

    // tol, segment A, segment B, verdict typed in, verdict
    stim_row_t directed_rows [NUM_ROWS] = '{
        // nothing moves at all: parallel by definition
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_DEGEN},
        '{0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
          1'b1, VERDICT_DEGEN},
        '{0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
          1'b1, VERDICT_DEGEN},
        // full-range diagonals crossing at the center
        '{0, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
          1'b1, VERDICT_PROPER},
        '{0, -100, 0, 100, 0, 0, -100, 0, 100, 1'b1, VERDICT_PROPER},
        // same cross with B reversed, so the cross product flips sign
        '{0, -100, 0, 100, 0, 0, 100, 0, -100, 1'b1, VERDICT_PROPER},
        // exact touch at the start and at the end of B
        '{0, -100, 0, 100, 0, 0, 0, 0, 100, 1'b0, VERDICT_NONE},
        '{0, -100, 0, 100, 0, 0, -100, 0, 0, 1'b0, VERDICT_NONE},
        // exact touch at the start and at the end of A
        '{0, 0, 0, 100, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        '{0, -100, 0, 0, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        // lines cross beyond A, then beyond B
        '{0, 10, 0, 100, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        '{0, -100, 0, 100, 0, 0, 50, 0, 100, 1'b0, VERDICT_NONE},
        '{0, 0, 0, 100, 0, 0, 10, 100, 10, 1'b1, VERDICT_DEGEN},
        '{0, 0, 0, 100, 0, 50, 0, 150, 0, 1'b1, VERDICT_DEGEN},
        '{0, 5, 5, 5, 5, 0, -100, 0, 100, 1'b1, VERDICT_DEGEN},
        '{0, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
          1'b0, VERDICT_NONE},
        // band of about one tenth: inside near each end, outside past it
        '{6554, -100, 0, 100, 0, 0, -5, 0, 95, 1'b0, VERDICT_NONE},
        '{6554, -100, 0, 100, 0, 0, 5, 0, 105, 1'b0, VERDICT_NONE},
        '{6554, -100, 0, 100, 0, 0, 20, 0, 120, 1'b0, VERDICT_NONE},
        '{6554, -100, 0, 100, 0, 0, -95, 0, 5, 1'b0, VERDICT_NONE},
        '{6554, -100, 0, 100, 0, 0, -105, 0, -5, 1'b0, VERDICT_NONE},
        '{6554, -100, 0, 100, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        '{32768, -100, 0, 100, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        '{65535, -100, 0, 100, 0, 0, -100, 0, 100, 1'b0, VERDICT_NONE},
        '{65535, -100, 0, 100, 0, 0, 50, 0, 100, 1'b0, VERDICT_NONE}
    };

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [TOL_WIDTH-1:0]                cfg_data      = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // tdata: a_start_x, a_start_y, a_end_x, a_end_y,
    //        b_start_x, b_start_y, b_end_x, b_end_y (lowest first)
    logic [NUM_COORDS*CW-1:0]            s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // tdata: verdict in [1:0], zero above
    logic [OUT_TDATA_WIDTH-1:0]          m_axis_tdata;

    logic [TOL_WIDTH-1:0] tolerance_q = '0;
    verdict_t             pending_verdicts [$];
    int                   error_count = 0;
    int                   pairs_sent = 0;
    int                   verdicts_seen = 0;
    int                   cycle_count = 0;
    bit                   send_quiet = 1'b0;
    bit                   recv_quiet = 1'b0;

    segment_intersection_test_core #(
        .COORD_WIDTH(CW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Exact verdict: the divisions by d become comparisons against d scaled
    // by the Q0.16 band, after d is made positive.
    function automatic verdict_t predict_verdict(input seg_pair_t p,
                                                 input logic [TOL_WIDTH-1:0] tol);
        longint dax, day, dbx, dby, rx, ry;
        longint d, ns, nt, ns16, band;
        dax  = longint'(p.a_end_x) - longint'(p.a_start_x);
        day  = longint'(p.a_end_y) - longint'(p.a_start_y);
        dbx  = longint'(p.b_end_x) - longint'(p.b_start_x);
        dby  = longint'(p.b_end_y) - longint'(p.b_start_y);
        rx   = longint'(p.a_start_x) - longint'(p.b_start_x);
        ry   = longint'(p.a_start_y) - longint'(p.b_start_y);
        band = tol;
        d    = dbx * day - dby * dax;
        if (d == 0)
            return VERDICT_DEGEN;
        ns = rx * day - ry * dax;
        nt = rx * dby - ry * dbx;
        if (d < 0)
        begin
            d  = -d;
            ns = -ns;
            nt = -nt;
        end
        ns16 = ns * 65536;
        if (ns16 < -(d * band) || ns16 > d * (65536 + band))
            return VERDICT_NONE;
        if (ns16 < d * band || ns16 > d * (65536 - band))
            return VERDICT_DEGEN;
        if (nt < 0 || nt > d)
            return VERDICT_NONE;
        return VERDICT_PROPER;
    endfunction

    function automatic seg_pair_t make_pair(input int ax0, ay0, ax1, ay1,
                                            input int bx0, by0, bx1, by1);
        seg_pair_t p;
        p.a_start_x = coord_t'(ax0);
        p.a_start_y = coord_t'(ay0);
        p.a_end_x   = coord_t'(ax1);
        p.a_end_y   = coord_t'(ay1);
        p.b_start_x = coord_t'(bx0);
        p.b_start_y = coord_t'(by0);
        p.b_end_x   = coord_t'(bx1);
        p.b_end_y   = coord_t'(by1);
        return p;
    endfunction

    function automatic int rand_span(input int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // Half the pairs are built to cross B near a chosen parameter, so the band
    // and endpoint cases come often; the rest is noise, parallel B and extremes.
    function automatic seg_pair_t random_pair();
        int kind, i, k, m, n, vx, vy, px, py;
        int c [8];
        kind = $urandom_range(0, 9);
        if (kind <= 1)
        begin
            for (i = 0; i < 8; i++)
                c[i] = $urandom;
        end
        else if (kind <= 6)
        begin
            for (i = 4; i < 8; i++)
                c[i] = rand_span(4000);
            // k/64 is the parameter along B; 0 and 64 hit the ends exactly
            k  = int'($urandom_range(0, 80)) - 8;
            px = c[4] + (c[6] - c[4]) * k / 64;
            py = c[5] + (c[7] - c[5]) * k / 64;
            vx = rand_span(200);
            vy = rand_span(200);
            m  = int'($urandom_range(0, 10)) - 2;
            n  = int'($urandom_range(0, 10)) - 2;
            c[0] = px - m * vx;
            c[1] = py - m * vy;
            c[2] = px + n * vx;
            c[3] = py + n * vy;
        end
        else if (kind == 7)
        begin
            // B along A's direction: parallel, collinear or zero length
            c[0] = rand_span(4000);
            c[1] = rand_span(4000);
            vx   = rand_span(300);
            vy   = rand_span(300);
            k    = rand_span(3);
            m    = rand_span(4);
            c[2] = c[0] + vx;
            c[3] = c[1] + vy;
            if ($urandom_range(0, 1) == 0)
            begin
                c[4] = c[0] + m * vx;
                c[5] = c[1] + m * vy;
            end
            else
            begin
                c[4] = rand_span(4000);
                c[5] = rand_span(4000);
            end
            c[6] = c[4] + k * vx;
            c[7] = c[5] + k * vy;
        end
        else if (kind == 8)
        begin
            for (i = 0; i < 8; i++)
                c[i] = rand_span(6);
        end
        else
        begin
            for (i = 0; i < 8; i++)
                case ($urandom_range(0, 5))
                    0:       c[i] = -32768;
                    1:       c[i] = 32767;
                    2:       c[i] = 0;
                    3:       c[i] = -1;
                    4:       c[i] = 1;
                    default: c[i] = $urandom;
                endcase
        end
        return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Tolerance changes only with the pipeline empty and the input idle.
    task automatic write_tolerance(input int value);
        // drop the input first so the last pair is not taken again
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        cfg_data      <= value[TOL_WIDTH-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        tolerance_q = value[TOL_WIDTH-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(input seg_pair_t pair, input bit typed,
                             input verdict_t want);
        int gap;
        if (pairs_sent % 32 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        pairs_sent++;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        pending_verdicts.push_back(typed ? want : predict_verdict(pair, tolerance_q));
    endtask

    initial
    begin
        int i, p, tol;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].tol != tolerance_q)
                write_tolerance(directed_rows[i].tol);
            send_pair(make_pair(directed_rows[i].ax0, directed_rows[i].ay0,
                                directed_rows[i].ax1, directed_rows[i].ay1,
                                directed_rows[i].bx0, directed_rows[i].by0,
                                directed_rows[i].bx1, directed_rows[i].by1),
                      directed_rows[i].typed, directed_rows[i].want);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            tol = (TOL_PHASES[p] == TOL_RANDOM) ? $urandom_range(0, 65535)
                                                : TOL_PHASES[p];
            write_tolerance(tol);
            repeat (PAIRS_PER_PHASE) send_pair(random_pair(), 1'b0, VERDICT_NONE);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // verdict side: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int stall;
        verdict_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (verdicts_seen % 32 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            stall = recv_quiet ? 0 : $urandom_range(0, 14);
            // hold long enough for the pipeline to fill and push back on input
            if (verdicts_seen == HOLD_AT_VERDICT)
                stall = HOLD_CYCLES;
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
                note_error($sformatf("verdict transaction 0x%02h with none pending",
                                     m_axis_tdata));
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata !== {{(OUT_TDATA_WIDTH-2){1'b0}}, want})
                    note_error($sformatf("verdict #%0d: expected %s (0x%02h), got 0x%02h",
                                         verdicts_seen, want.name(),
                                         {{(OUT_TDATA_WIDTH-2){1'b0}}, want},
                                         m_axis_tdata));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d verdicts pending",
                 cycle_count, pending_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
